@@ rtl/mdrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mdrt_pkg
// Shared types, codes and sizes of the dispatch rule table.
// ----------------------------------------------------------------------------
package mdrt_pkg;

	localparam int TableEntries = 8;
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW = $clog2(TableEntries + 1);

	// request action codes
	localparam logic [1:0] ActAdd      = 2'd0;
	localparam logic [1:0] ActRemove   = 2'd1;
	localparam logic [1:0] ActDispatch = 2'd2;
	localparam logic [1:0] ActUnused   = 2'd3;

	// response status codes
	localparam logic [1:0] StOk   = 2'd0;
	localparam logic [1:0] StFull = 2'd1;
	localparam logic [1:0] StNone = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] header_word;
		logic [15:0] min_length;
		logic [15:0] max_length;
		logic [7:0]  handler_tag;
		logic [15:0] message_length;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] matched_tag;
		logic [3:0] rule_count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_DISPATCH,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] header;
		logic [15:0] min_len;
		logic [15:0] max_len;
		logic [7:0]  tag;
		logic [15:0] msg_len;
	} cmd_t;

endpackage

@@ rtl/message_dispatch_rule_table.sv @@
// ----------------------------------------------------------------------------
// message_dispatch_rule_table
// Ordered first-match rule table: add, remove by tag, dispatch a message.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req) carries one transaction per
// command: add a rule, remove the first rule with a tag, or dispatch a
// message header word and length. Response channel (rsp_valid / rsp_stall /
// rsp) returns exactly one transaction per request, in request order, with
// status, matched tag and the rule count after the command.
// A two-entry queue sits between the request decoder and the table
// sequencer; the sequencer visits one rule per cycle on its single read port.
// Work per request at the sequencer:
//   add or unused action: result set when taken, then reported
//   dispatch: scan of the rules (scan stops at the first match)
//   remove: scan to the tag, then move later rules up
// rsp_valid rises when the report state loads the response into the
// output register.
// The sequencer takes the next request once its response has entered the
// output register; while rsp_stall is high the response holds, the queue
// fills and req_stall rises when both queue entries are taken.
// Reset empties the queue, the output register and the table; rule
// storage itself is not cleared.
// ----------------------------------------------------------------------------
module message_dispatch_rule_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mdrt_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mdrt_pkg::rsp_item_t rsp
);

	logic           cmd_valid;
	logic           cmd_take;
	mdrt_pkg::cmd_t cmd;

	mdrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	mdrt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/mdrt_front.sv @@
// ----------------------------------------------------------------------------
// mdrt_front
// Accepts requests, decodes the action and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mdrt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mdrt_pkg::req_item_t req,
	output logic                cmd_valid,
	input  logic                cmd_take,
	output mdrt_pkg::cmd_t      cmd
);

	mdrt_pkg::cmd_t queue_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           pop;
	mdrt_pkg::cmd_t decoded;

	always_comb begin
		case (req.action)
			mdrt_pkg::ActAdd:      decoded.op = mdrt_pkg::OP_ADD;
			mdrt_pkg::ActRemove:   decoded.op = mdrt_pkg::OP_REMOVE;
			mdrt_pkg::ActDispatch: decoded.op = mdrt_pkg::OP_DISPATCH;
			default:               decoded.op = mdrt_pkg::OP_IGNORE;
		endcase
		decoded.header  = req.header_word;
		decoded.min_len = req.min_length;
		decoded.max_len = req.max_length;
		decoded.tag     = req.handler_tag;
		decoded.msg_len = req.message_length;
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ rtl/mdrt_back.sv @@
// ----------------------------------------------------------------------------
// mdrt_back
// Rule store and sequencer: appends, scans and compacts the rule table one
// entry per cycle, and holds the response in an output register.
// ----------------------------------------------------------------------------
module mdrt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_take,
	input  mdrt_pkg::cmd_t      cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mdrt_pkg::rsp_item_t rsp
);

	typedef struct packed {
		logic [31:0] header;
		logic [15:0] min_len;
		logic [15:0] max_len;
		logic [7:0]  tag;
	} rule_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_REPORT
	} state_t;

	state_t                        state_q;
	rule_t                         rules_q [mdrt_pkg::TableEntries];
	logic [mdrt_pkg::CntW-1:0]     cnt_q;
	logic [mdrt_pkg::CntW-1:0]     idx_q;
	mdrt_pkg::cmd_t                cmd_q;
	mdrt_pkg::rsp_item_t           res_q;
	logic                          rsp_valid_q;
	mdrt_pkg::rsp_item_t           rsp_q;

	logic [mdrt_pkg::CntW-1:0]     idx_next;
	logic [mdrt_pkg::CntW-1:0]     rd_addr;
	rule_t                         rd_rule;
	logic                          full;
	logic                          in_range;
	logic                          shift_more;
	logic                          hit_remove;
	logic                          len_ok;
	logic                          hit_dispatch;
	logic                          wr_en;
	logic [mdrt_pkg::IdxW-1:0]     wr_addr;
	rule_t                         wr_rule;
	logic                          rsp_load;

	assign idx_next   = idx_q + mdrt_pkg::CntW'(1);
	assign rd_addr    = (state_q == ST_SHIFT) ? idx_next : idx_q;
	assign rd_rule    = rules_q[rd_addr[mdrt_pkg::IdxW-1:0]];
	assign full       = (cnt_q == mdrt_pkg::CntW'(mdrt_pkg::TableEntries));
	assign in_range   = (idx_q < cnt_q);
	assign shift_more = (idx_next < cnt_q);
	assign hit_remove = (rd_rule.tag == cmd_q.tag);
	assign len_ok     = ((rd_rule.min_len == 16'd0) || (cmd_q.msg_len >= rd_rule.min_len)) &&
	                    ((rd_rule.max_len == 16'd0) || (cmd_q.msg_len <= rd_rule.max_len));
	assign hit_dispatch = (rd_rule.tag != 8'd0) && (rd_rule.header == cmd_q.header) && len_ok;
	assign cmd_take   = (state_q == ST_IDLE) && cmd_valid;
	// load the output register once it is empty or being drained
	assign rsp_load   = (state_q == ST_REPORT) && (!rsp_valid_q || !rsp_stall);

	// append in the take cycle, move the next rule up one place while compacting
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[mdrt_pkg::IdxW-1:0];
		wr_rule = '{header: cmd.header, min_len: cmd.min_len, max_len: cmd.max_len,
		            tag: cmd.tag};
		if (cmd_take && (cmd.op == mdrt_pkg::OP_ADD) && !full) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_SHIFT) && shift_more) begin
			wr_en   = 1'b1;
			wr_addr = idx_q[mdrt_pkg::IdxW-1:0];
			wr_rule = rd_rule;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rules_q[wr_addr] <= wr_rule;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			cmd_q       <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						cmd_q <= cmd;
						idx_q <= '0;
						case (cmd.op)
							mdrt_pkg::OP_ADD: begin
								if (full) begin
									res_q <= '{status: mdrt_pkg::StFull, matched_tag: 8'd0,
									           rule_count: 4'(cnt_q)};
								end else begin
									cnt_q <= cnt_q + mdrt_pkg::CntW'(1);
									res_q <= '{status: mdrt_pkg::StOk, matched_tag: 8'd0,
									           rule_count: 4'(cnt_q + mdrt_pkg::CntW'(1))};
								end
								state_q <= ST_REPORT;
							end
							mdrt_pkg::OP_REMOVE,
							mdrt_pkg::OP_DISPATCH: begin
								state_q <= ST_SCAN;
							end
							default: begin
								res_q <= '{status: mdrt_pkg::StNone, matched_tag: 8'd0,
								           rule_count: 4'(cnt_q)};
								state_q <= ST_REPORT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!in_range) begin
						res_q <= '{status: mdrt_pkg::StNone, matched_tag: 8'd0,
						           rule_count: 4'(cnt_q)};
						state_q <= ST_REPORT;
					end else if ((cmd_q.op == mdrt_pkg::OP_REMOVE) && hit_remove) begin
						state_q <= ST_SHIFT;
					end else if ((cmd_q.op == mdrt_pkg::OP_DISPATCH) && hit_dispatch) begin
						res_q <= '{status: mdrt_pkg::StOk, matched_tag: rd_rule.tag,
						           rule_count: 4'(cnt_q)};
						state_q <= ST_REPORT;
					end else begin
						idx_q <= idx_next;
					end
				end
				ST_SHIFT: begin
					if (shift_more) begin
						idx_q <= idx_next;
					end else begin
						cnt_q <= cnt_q - mdrt_pkg::CntW'(1);
						res_q <= '{status: mdrt_pkg::StOk, matched_tag: 8'd0,
						           rule_count: 4'(cnt_q - mdrt_pkg::CntW'(1))};
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					// hold until the output register is free
					if (rsp_load) begin
						rsp_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mdrt_pkg::CntW'(mdrt_pkg::TableEntries))
		else $error("rule count exceeds table size");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (idx_q < cnt_q))
		else $error("compaction index beyond last rule");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after taking a transaction");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && (cmd.op == mdrt_pkg::OP_ADD) && !full) |=>
		(cnt_q == $past(cnt_q) + mdrt_pkg::CntW'(1)))
		else $error("accepted add did not grow the table");

endmodule

@@ tb/mdrt_rule_checker.sv @@
// ----------------------------------------------------------------------------
// mdrt_rule_checker
// Watches both channels of the dispatch rule table, keeps its own copy of the
// rule table, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module mdrt_rule_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  mdrt_pkg::req_item_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  mdrt_pkg::rsp_item_t rsp,
	output int                  mismatch_count,
	output int                  replies_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0]         shadow_header [mdrt_pkg::TableEntries];
	logic [15:0]         shadow_min [mdrt_pkg::TableEntries];
	logic [15:0]         shadow_max [mdrt_pkg::TableEntries];
	logic [7:0]          shadow_tag [mdrt_pkg::TableEntries];
	int                  rule_total = 0;
	int                  errs = 0;
	mdrt_pkg::rsp_item_t expected_replies [$];

	// Apply one command to the shadow table and return the response it causes.
	function automatic mdrt_pkg::rsp_item_t apply_rule_command(input mdrt_pkg::req_item_t r);
		int                  i;
		int                  hit;
		mdrt_pkg::rsp_item_t o;
		o.status = mdrt_pkg::StNone;
		o.matched_tag = 8'd0;
		hit = -1;
		case (r.action)
			mdrt_pkg::ActAdd: begin
				if (rule_total >= mdrt_pkg::TableEntries) begin
					o.status = mdrt_pkg::StFull;
				end else begin
					shadow_header[rule_total] = r.header_word;
					shadow_min[rule_total] = r.min_length;
					shadow_max[rule_total] = r.max_length;
					shadow_tag[rule_total] = r.handler_tag;
					rule_total++;
					o.status = mdrt_pkg::StOk;
				end
			end
			mdrt_pkg::ActRemove: begin
				for (i = 0; i < rule_total; i++)
					if (hit < 0 && shadow_tag[i] == r.handler_tag)
						hit = i;
				if (hit >= 0) begin
					// move later rules up, keeping their order
					for (i = hit; i < rule_total - 1; i++) begin
						shadow_header[i] = shadow_header[i + 1];
						shadow_min[i] = shadow_min[i + 1];
						shadow_max[i] = shadow_max[i + 1];
						shadow_tag[i] = shadow_tag[i + 1];
					end
					rule_total--;
					o.status = mdrt_pkg::StOk;
				end
			end
			mdrt_pkg::ActDispatch: begin
				for (i = 0; i < rule_total; i++) begin
					if (o.status == mdrt_pkg::StNone && shadow_tag[i] != 8'd0 &&
							shadow_header[i] == r.header_word &&
							(shadow_min[i] == 16'd0 || r.message_length >= shadow_min[i]) &&
							(shadow_max[i] == 16'd0 || r.message_length <= shadow_max[i])) begin
						o.matched_tag = shadow_tag[i];
						o.status = mdrt_pkg::StOk;
					end
				end
			end
			default: begin
			end
		endcase
		o.rule_count = 4'(rule_total);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mdrt_pkg::rsp_item_t want;
		if (!arst_n) begin
			rule_total = 0;
			expected_replies.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected response transaction: status %0d tag %0d count %0d",
						rsp.status, rsp.matched_tag, rsp.rule_count);
					errs++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
					if (rsp.matched_tag !== want.matched_tag) begin
						$error("matched_tag: expected %0d, got %0d",
							want.matched_tag, rsp.matched_tag);
						errs++;
					end
					if (rsp.rule_count !== want.rule_count) begin
						$error("rule_count: expected %0d, got %0d",
							want.rule_count, rsp.rule_count);
						errs++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_replies.push_back(apply_rule_command(req));
		end
		replies_pending <= expected_replies.size();
		mismatch_count <= errs;
	end

endmodule

@@ tb/tb_message_dispatch_rule_table.sv @@
// ----------------------------------------------------------------------------
// tb_message_dispatch_rule_table
// Drives add, remove, dispatch and unused transactions into the rule table: a short
// directed run over bounds, null rules and a full table, then biased random
// traffic with random idle bursts on both channels. A checker judges results.
// ----------------------------------------------------------------------------
module tb_message_dispatch_rule_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 626;
	localparam int QuietTail = 80;
	localparam int WatchdogLimit = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	mdrt_pkg::req_item_t req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	mdrt_pkg::rsp_item_t rsp;
	int                  mismatch_count;
	int                  replies_pending;
	logic                quiet = 1'b0;
	int                  idle_cycles = 0;

	logic [31:0] header_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_A5A5, 32'h1234_5678};

	message_dispatch_rule_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	mdrt_rule_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.mismatch_count  (mismatch_count),
		.replies_pending (replies_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Response backpressure: stall bursts between free-running stretches.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic mdrt_pkg::req_item_t rule_req(input logic [1:0] action,
			input logic [31:0] header, input logic [15:0] lo, input logic [15:0] hi,
			input logic [7:0] tag, input logic [15:0] len);
		mdrt_pkg::req_item_t r;
		r.action = action;
		r.header_word = header;
		r.min_length = lo;
		r.max_length = hi;
		r.handler_tag = tag;
		r.message_length = len;
		return r;
	endfunction

	// Mostly pooled headers and small tags so that dispatches hit and removes
	// find their rule; full-range values now and then.
	function automatic mdrt_pkg::req_item_t random_rule_req();
		mdrt_pkg::req_item_t r;
		int                  pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.action = mdrt_pkg::ActAdd;
		else if (pick < 60)
			r.action = mdrt_pkg::ActRemove;
		else if (pick < 97)
			r.action = mdrt_pkg::ActDispatch;
		else
			r.action = mdrt_pkg::ActUnused;
		r.header_word = ($urandom_range(0, 99) < 85) ? header_pool[$urandom_range(0, 3)]
			: 32'($urandom);
		r.handler_tag = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 6))
			: 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 9);
		r.min_length = (pick < 4) ? 16'd0 : (pick < 8) ? 16'($urandom_range(1, 40))
			: 16'($urandom);
		pick = $urandom_range(0, 9);
		r.max_length = (pick < 4) ? 16'd0 : (pick < 8) ? 16'($urandom_range(20, 64))
			: 16'($urandom);
		r.message_length = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 80))
			: 16'($urandom);
		return r;
	endfunction

	task automatic send_request(input mdrt_pkg::req_item_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic sender_gap(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		mdrt_pkg::req_item_t r;
		int                  counted;
		counted = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		send_request(rule_req(mdrt_pkg::ActAdd, 32'h0000_0000, 16'h0000, 16'h0000, 8'd1,
			16'd0));
		send_request(rule_req(mdrt_pkg::ActAdd, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
			16'hFFFF));
		// null handler ahead of a bounded rule with the same header
		send_request(rule_req(mdrt_pkg::ActAdd, 32'h0000_A5A5, 16'd0, 16'd0, 8'd0, 16'd0));
		send_request(rule_req(mdrt_pkg::ActAdd, 32'h0000_A5A5, 16'd10, 16'd20, 8'd5, 16'd0));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_A5A5, 16'd0, 16'd0, 8'd0, 16'd9));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_A5A5, 16'd0, 16'd0, 8'd0, 16'd10));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_A5A5, 16'd0, 16'd0, 8'd0, 16'd20));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_A5A5, 16'd0, 16'd0, 8'd0, 16'd21));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 8'hFF,
			16'hFFFF));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'hFFFF_FFFF, 16'd0, 16'd0, 8'd0,
			16'hFFFF));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'hFFFF_FFFF, 16'd0, 16'd0, 8'd0, 16'd0));
		send_request(rule_req(mdrt_pkg::ActAdd, 32'h0000_A5A5, 16'd0, 16'd0, 8'd6, 16'd0));
		send_request(rule_req(mdrt_pkg::ActAdd, 32'h0000_A5A5, 16'd30, 16'd0, 8'd7, 16'd0));
		send_request(rule_req(mdrt_pkg::ActAdd, 32'h1234_5678, 16'd0, 16'd100, 8'd8, 16'd0));
		send_request(rule_req(mdrt_pkg::ActAdd, 32'h0000_0000, 16'd0, 16'd0, 8'd9, 16'd0));
		// table is full now
		send_request(rule_req(mdrt_pkg::ActAdd, 32'hDEAD_BEEF, 16'd1, 16'd2, 8'd10, 16'd0));
		send_request(rule_req(mdrt_pkg::ActRemove, 32'h0, 16'd0, 16'd0, 8'd5, 16'd0));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_A5A5, 16'd0, 16'd0, 8'd0, 16'd15));
		send_request(rule_req(mdrt_pkg::ActRemove, 32'h0, 16'd0, 16'd0, 8'd77, 16'd0));
		send_request(rule_req(mdrt_pkg::ActRemove, 32'h0, 16'd0, 16'd0, 8'd0, 16'd0));
		send_request(rule_req(mdrt_pkg::ActUnused, 32'($urandom), 16'($urandom),
			16'($urandom), 8'($urandom), 16'($urandom)));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_0000, 16'd0, 16'd0, 8'd0, 16'd3));
		send_request(rule_req(mdrt_pkg::ActRemove, 32'h0, 16'd0, 16'd0, 8'd1, 16'd0));
		send_request(rule_req(mdrt_pkg::ActDispatch, 32'h0000_0000, 16'd0, 16'd0, 8'd0, 16'd3));

		// hold off until every outstanding response is back
		sender_gap(1);
		while (replies_pending != 0) @(posedge clk);

		while (counted < RandomItems) begin
			r = random_rule_req();
			send_request(r);
			counted++;
			if (counted >= RandomItems - QuietTail)
				quiet <= 1'b1;
			else if ($urandom_range(0, 4) == 0)
				sender_gap($urandom_range(1, 16));
		end

		sender_gap(1);
		while (replies_pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/mdrt_pkg.sv
rtl/mdrt_front.sv
rtl/mdrt_back.sv
rtl/message_dispatch_rule_table.sv
tb/mdrt_rule_checker.sv
tb/tb_message_dispatch_rule_table.sv
